>>> hdl/bir_pkg.sv
`timescale 1ns / 1ps
package bir_pkg;

  localparam int MAX_SRC_WIDTH  = 256;
  localparam int MAX_SRC_HEIGHT = 256;
  localparam int MAX_DST_SIZE   = 1024;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [2:0] REG_NEAREST    = 3'd4;

  localparam int CFG_DATA_W = 11;
  localparam int CFG_INDEX_W = 3;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  src_x;
    logic [7:0]  src_y;
    logic [23:0] pixel_in;
    logic [9:0]  out_x;
    logic [9:0]  out_y;
  } item_t;

endpackage

>>> hdl/bir_item_if.sv
`timescale 1ns / 1ps
interface bir_item_if;
  logic valid;
  logic ready;
  logic        cmd;
  logic [7:0]  src_x;
  logic [7:0]  src_y;
  logic [23:0] pixel_in;
  logic [9:0]  out_x;
  logic [9:0]  out_y;
  modport source (output valid, cmd, src_x, src_y, pixel_in, out_x, out_y, input ready);
  modport sink (input valid, cmd, src_x, src_y, pixel_in, out_x, out_y, output ready);
endinterface

>>> hdl/bir_pixel_if.sv
`timescale 1ns / 1ps
interface bir_pixel_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_out;
  modport source (output valid, pixel_out, input ready);
  modport sink (input valid, pixel_out, output ready);
endinterface

>>> hdl/bilinear_image_resize_unit.sv
`timescale 1ns / 1ps
// Bilinear resize of a stored RGB source image (nearest neighbor when REG_NEAREST is set).
// A write transaction (cmd 0) stores one pixel. A request (cmd 1) returns one pixel after two
// rounds of serial division (one quotient bit per cycle, 19 bits each, integer position then
// fraction) followed by four neighbor reads from the source memory, each a read, a weight
// multiply and an accumulate in the TAP, MUL and ACC states. A two-entry queue decouples
// accepting items from that work.
module bilinear_image_resize_unit #(
  parameter int FRAC_BITS      = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  bir_item_if.sink                     in_item,
  bir_pixel_if.source                  out_pixel,
  input  logic                         cfg_we,
  input  logic [bir_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bir_pkg::CFG_DATA_W-1:0]  cfg_data
);
  localparam int SW = $clog2(bir_pkg::MAX_SRC_WIDTH);
  localparam int SH = $clog2(bir_pkg::MAX_SRC_HEIGHT);
  localparam int DB = $clog2(bir_pkg::MAX_DST_SIZE + 1);

  logic [SW:0]   src_width;
  logic [SH:0]   src_height;
  logic [DB-1:0] dst_width;
  logic [DB-1:0] dst_height;
  logic          nearest_mode;

  function automatic logic [12:0] clampv(input logic [10:0] v, input logic [12:0] hi);
    logic [12:0] w;
    w = {2'b00, v};
    if (w == 13'd0) return 13'd1;
    if (w > hi) return hi;
    return w;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width <= (SW + 1)'(bir_pkg::MAX_SRC_WIDTH < 256 ? bir_pkg::MAX_SRC_WIDTH : 256);
      src_height <= (SH + 1)'(bir_pkg::MAX_SRC_HEIGHT < 256 ? bir_pkg::MAX_SRC_HEIGHT : 256);
      dst_width <= DB'(bir_pkg::MAX_DST_SIZE < 256 ? bir_pkg::MAX_DST_SIZE : 256);
      dst_height <= DB'(bir_pkg::MAX_DST_SIZE < 256 ? bir_pkg::MAX_DST_SIZE : 256);
      nearest_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bir_pkg::REG_SRC_WIDTH:
          src_width <= (SW + 1)'(clampv({2'b00, cfg_data[8:0]},
                                        13'(bir_pkg::MAX_SRC_WIDTH)));
        bir_pkg::REG_SRC_HEIGHT:
          src_height <= (SH + 1)'(clampv({2'b00, cfg_data[8:0]},
                                         13'(bir_pkg::MAX_SRC_HEIGHT)));
        bir_pkg::REG_DST_WIDTH:
          dst_width <= DB'(clampv(cfg_data, 13'(bir_pkg::MAX_DST_SIZE)));
        bir_pkg::REG_DST_HEIGHT:
          dst_height <= DB'(clampv(cfg_data, 13'(bir_pkg::MAX_DST_SIZE)));
        bir_pkg::REG_NEAREST: nearest_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  bir_pkg::item_t in_data;
  bir_pkg::item_t q_data;
  logic q_full, q_empty, q_pop, push;

  // Writes outside the store are dropped at the front end.
  logic in_range;
  assign in_range = (in_item.cmd == bir_pkg::CMD_READ) ||
                    ((16'(in_item.src_x) < 16'(bir_pkg::MAX_SRC_WIDTH)) &&
                     (16'(in_item.src_y) < 16'(bir_pkg::MAX_SRC_HEIGHT)));
  assign in_data = '{cmd: in_item.cmd, src_x: in_item.src_x, src_y: in_item.src_y,
                     pixel_in: in_item.pixel_in, out_x: in_item.out_x, out_y: in_item.out_y};
  assign in_item.ready = !q_full;
  assign push = in_item.valid && !q_full && in_range;

  bir_queue u_queue (
    .clk, .rst, .push, .push_data(in_data), .full(q_full),
    .pop(q_pop), .pop_data(q_data), .empty(q_empty));

  bir_engine #(.SRC_W_BITS(SW), .SRC_H_BITS(SH), .DST_BITS(DB), .FRAC_BITS(FRAC_BITS)) u_engine (
    .clk, .rst, .item_valid(!q_empty), .item(q_data), .item_pop(q_pop),
    .src_width, .src_height, .dst_width, .dst_height, .nearest_mode,
    .res_valid(out_pixel.valid), .res_ready(out_pixel.ready), .res_pixel(out_pixel.pixel_out));
endmodule

>>> hdl/bir_queue.sv
`timescale 1ns / 1ps
// Two-entry queue between front and back end.
module bir_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bir_pkg::item_t   push_data,
  output logic             full,
  input  logic             pop,
  output bir_pkg::item_t   pop_data,
  output logic             empty
);
  bir_pkg::item_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count invalid");
endmodule

>>> hdl/bir_divider.sv
`timescale 1ns / 1ps
// Restoring divider: one quotient bit per cycle.
module bir_divider #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             done,
  output logic [NUM_W-1:0] quot,
  output logic [DEN_W-1:0] rem
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] shreg;
  logic [DEN_W:0]   part;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  assign trial = {part[DEN_W-1:0], shreg[NUM_W-1]};
  assign diff = trial - {1'b0, denom};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        shreg <= numer;
        part <= '0;
        cnt <= CNT_W'(NUM_W);
      end else if (busy) begin
        if (!diff[DEN_W]) begin
          part <= diff;
          shreg <= {shreg[NUM_W-2:0], 1'b1};
        end else begin
          part <= trial;
          shreg <= {shreg[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = shreg;
  assign rem = part[DEN_W-1:0];
endmodule

>>> hdl/bir_engine.sv
`timescale 1ns / 1ps
// Back end: holds the source store, writes pixels, and computes resized pixels.
module bir_engine #(
  parameter int SRC_W_BITS = 8,
  parameter int SRC_H_BITS = 8,
  parameter int DST_BITS   = 11,
  parameter int FRAC_BITS  = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  bir_pkg::item_t        item,
  output logic                  item_pop,
  input  logic [SRC_W_BITS:0]   src_width,
  input  logic [SRC_H_BITS:0]   src_height,
  input  logic [DST_BITS-1:0]   dst_width,
  input  logic [DST_BITS-1:0]   dst_height,
  input  logic                  nearest_mode,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic [23:0]           res_pixel
);
  localparam int SW = SRC_W_BITS;
  localparam int SH = SRC_H_BITS;
  localparam int AW = SW + SH;
  localparam int NUMX_W = 10 + SW + 1;
  localparam int NUMY_W = 10 + SH + 1;
  localparam int FNUM_W = DST_BITS + FRAC_BITS;
  localparam int WT_W = FRAC_BITS + 1;
  localparam int PROD_W = 2 * WT_W;
  localparam int ACC_W = PROD_W + 10;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DIVI  = 4'd1;
  localparam logic [3:0] ST_WAITI = 4'd2;
  localparam logic [3:0] ST_DIVF  = 4'd3;
  localparam logic [3:0] ST_WAITF = 4'd4;
  localparam logic [3:0] ST_TAP   = 4'd5;
  localparam logic [3:0] ST_MUL   = 4'd6;
  localparam logic [3:0] ST_ACC   = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  logic [3:0] state;
  logic [23:0] mem [2**AW];
  logic [23:0] rdata;
  logic [AW-1:0] raddr;

  logic        dx_start, dy_start;
  logic [NUMX_W-1:0] numx;
  logic [NUMY_W-1:0] numy;
  logic        dx_done, dy_done;
  logic [NUMX_W-1:0] qx;
  logic [NUMY_W-1:0] qy;
  logic [DST_BITS-1:0] rx, ry;
  logic        fx_start, fy_start;
  logic        fx_done, fy_done;
  logic [FNUM_W-1:0] qfx, qfy;
  logic [DST_BITS-1:0] rfx_unused, rfy_unused;

  logic [NUMX_W-1:0] ix;
  logic [NUMY_W-1:0] iy;
  logic [FRAC_BITS-1:0] fx, fy;
  logic [1:0] tap;
  logic       tap_in;
  logic [PROD_W-1:0] wgt;
  logic [ACC_W-1:0] acc [3];
  logic [NUMX_W:0] tx;
  logic [NUMY_W:0] ty;
  logic [WT_W-1:0] wx, wy;
  logic [WT_W-1:0] one_w;
  logic [ACC_W-1:0] half;

  assign one_w = WT_W'(1) << FRAC_BITS;
  assign half = ACC_W'(1) << (2 * FRAC_BITS - 1);

  assign numx = NUMX_W'(item.out_x) * NUMX_W'(src_width);
  assign numy = NUMY_W'(item.out_y) * NUMY_W'(src_height);

  bir_divider #(.NUM_W(NUMX_W), .DEN_W(DST_BITS)) u_divx (
    .clk, .rst, .start(dx_start), .numer(numx), .denom(dst_width),
    .done(dx_done), .quot(qx), .rem(rx));
  bir_divider #(.NUM_W(NUMY_W), .DEN_W(DST_BITS)) u_divy (
    .clk, .rst, .start(dy_start), .numer(numy), .denom(dst_height),
    .done(dy_done), .quot(qy), .rem(ry));
  bir_divider #(.NUM_W(FNUM_W), .DEN_W(DST_BITS)) u_divfx (
    .clk, .rst, .start(fx_start), .numer({rx, FRAC_BITS'(0)}), .denom(dst_width),
    .done(fx_done), .quot(qfx), .rem(rfx_unused));
  bir_divider #(.NUM_W(FNUM_W), .DEN_W(DST_BITS)) u_divfy (
    .clk, .rst, .start(fy_start), .numer({ry, FRAC_BITS'(0)}), .denom(dst_height),
    .done(fy_done), .quot(qfy), .rem(rfy_unused));

  always_comb begin
    tx = {1'b0, ix} + (NUMX_W + 1)'(tap[1]);
    ty = {1'b0, iy} + (NUMY_W + 1)'(tap[0]);
    raddr = {ty[SH-1:0], tx[SW-1:0]};
    if (nearest_mode) begin
      wx = tap[1] ? '0 : one_w;
      wy = tap[0] ? '0 : one_w;
    end else begin
      wx = tap[1] ? {1'b0, fx} : one_w - {1'b0, fx};
      wy = tap[0] ? {1'b0, fy} : one_w - {1'b0, fy};
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_valid && item.cmd == bir_pkg::CMD_WRITE) begin
      mem[{item.src_y[SH-1:0], item.src_x[SW-1:0]}] <= item.pixel_in;
    end
    rdata <= mem[raddr];
  end

  assign item_pop = (state == ST_IDLE) && item_valid && (item.cmd == bir_pkg::CMD_WRITE)
                    || (state == ST_DIVI);
  assign dx_start = (state == ST_DIVI);
  assign dy_start = (state == ST_DIVI);
  assign fx_start = (state == ST_DIVF);
  assign fy_start = (state == ST_DIVF);
  assign res_valid = (state == ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (item_valid && item.cmd == bir_pkg::CMD_READ) state <= ST_DIVI;
        end
        ST_DIVI: state <= ST_WAITI;
        ST_WAITI: begin
          if (dx_done) begin
            ix <= qx;
            iy <= qy;
            state <= ST_DIVF;
          end
        end
        ST_DIVF: state <= ST_WAITF;
        ST_WAITF: begin
          if (fx_done) begin
            fx <= qfx[FRAC_BITS-1:0];
            fy <= qfy[FRAC_BITS-1:0];
            tap <= 2'd0;
            acc[0] <= '0;
            acc[1] <= '0;
            acc[2] <= '0;
            state <= ST_TAP;
          end
        end
        ST_TAP: begin
          // Memory read is registered; weight and range check travel alongside.
          tap_in <= (tx < (NUMX_W + 1)'(src_width)) && (ty < (NUMY_W + 1)'(src_height));
          wgt <= wx * wy;
          state <= ST_MUL;
        end
        ST_MUL: state <= ST_ACC;
        ST_ACC: begin
          if (tap_in) begin
            acc[0] <= acc[0] + ACC_W'(rdata[23:16]) * ACC_W'(wgt);
            acc[1] <= acc[1] + ACC_W'(rdata[15:8]) * ACC_W'(wgt);
            acc[2] <= acc[2] + ACC_W'(rdata[7:0]) * ACC_W'(wgt);
          end
          tap <= tap + 2'd1;
          state <= (tap == 2'd3) ? ST_OUT : ST_TAP;
        end
        ST_OUT: begin
          if (res_ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    logic [ACC_W-1:0] r0, r1, r2;
    r0 = (acc[0] + half) >> (2 * FRAC_BITS);
    r1 = (acc[1] + half) >> (2 * FRAC_BITS);
    r2 = (acc[2] + half) >> (2 * FRAC_BITS);
    res_pixel = {r0[7:0], r1[7:0], r2[7:0]};
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_pixel))
    else $error("result changed while stalled");
  a_div_pair: assert property (@(posedge clk) disable iff (rst) dx_done == dy_done)
    else $error("axis dividers out of step");
  a_frac_pair: assert property (@(posedge clk) disable iff (rst) fx_done == fy_done)
    else $error("fraction dividers out of step");
endmodule
